@@ hdl/vehicle_lateral_model_step_top_macros.svh @@
// Assertion macros used by the block's checker.
`ifndef VEHICLE_LATERAL_MODEL_STEP_TOP_MACROS_SVH
`define VEHICLE_LATERAL_MODEL_STEP_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define VLM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vlm check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define VLM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vlm check failed");

`endif

@@ hdl/vlm_pkg.sv @@
// ----------------------------------------------------------------------------
// vlm_pkg
// Shared types, constants and helper functions of the lateral model step.
// ----------------------------------------------------------------------------
package vlm_pkg;

  localparam int unsigned CordicTableLen     = 30;
  localparam int unsigned CordicIterDefault  = 20;
  localparam int unsigned MinDynSpeedDefault = 327680;
  localparam int unsigned IterW              = $clog2(CordicTableLen + 1);

  typedef logic signed [63:0] word_t;

  localparam word_t Q30HalfPi  = 64'sd1686629713;
  localparam word_t Q30Pi      = 64'sd3373259426;
  localparam word_t Q30InvGain = 64'sd652032874;
  localparam word_t Int32Max   = 64'sd2147483647;
  localparam word_t Int32Min   = -64'sd2147483648;

  // Register reset values
  localparam logic [19:0] FrontAxleRst = 20'd78643;
  localparam logic [19:0] RearAxleRst  = 20'd91750;
  localparam logic [18:0] FrontTrackRst = 19'd98304;
  localparam logic [18:0] RearTrackRst  = 19'd98304;
  localparam logic [19:0] FrontStiffRst = 20'd80000;
  localparam logic [19:0] RearStiffRst  = 20'd80000;
  localparam logic [15:0] MassRst       = 16'd1500;
  localparam logic [17:0] InertiaRst    = 18'd2500;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MUL,
    OP_DIV,
    OP_SQRT,
    OP_ROT,
    OP_VEC
  } op_e;

  typedef enum logic [2:0] {
    CFG_FRONT_AXLE,
    CFG_REAR_AXLE,
    CFG_FRONT_TRACK,
    CFG_REAR_TRACK,
    CFG_FRONT_STIFF,
    CFG_REAR_STIFF,
    CFG_MASS,
    CFG_INERTIA
  } cfg_idx_e;

  typedef struct packed {
    logic  valid;
    op_e   op;
    word_t a;
    word_t b;
  } unit_req_t;

  typedef struct packed {
    logic  done;
    logic  flag;
    word_t res_a;
    word_t res_b;
  } unit_rsp_t;

  // Arctangent of 2^-i in Q30
  function automatic word_t atan_entry(input logic [IterW-1:0] idx);
    word_t v;
    case (idx)
      5'd0:  v = 64'sd843314857;
      5'd1:  v = 64'sd497837830;
      5'd2:  v = 64'sd263043837;
      5'd3:  v = 64'sd133525159;
      5'd4:  v = 64'sd67021687;
      5'd5:  v = 64'sd33543515;
      5'd6:  v = 64'sd16775851;
      5'd7:  v = 64'sd8388437;
      5'd8:  v = 64'sd4194283;
      5'd9:  v = 64'sd2097149;
      5'd10: v = 64'sd1048576;
      5'd11: v = 64'sd524288;
      5'd12: v = 64'sd262144;
      5'd13: v = 64'sd131072;
      5'd14: v = 64'sd65536;
      5'd15: v = 64'sd32768;
      5'd16: v = 64'sd16384;
      5'd17: v = 64'sd8192;
      5'd18: v = 64'sd4096;
      5'd19: v = 64'sd2048;
      5'd20: v = 64'sd1024;
      5'd21: v = 64'sd512;
      5'd22: v = 64'sd256;
      5'd23: v = 64'sd128;
      5'd24: v = 64'sd64;
      5'd25: v = 64'sd32;
      5'd26: v = 64'sd16;
      5'd27: v = 64'sd8;
      5'd28: v = 64'sd4;
      5'd29: v = 64'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round half up, then arithmetic shift right
  function automatic word_t rnd_shift(input word_t v, input int unsigned n);
    return (v + (word_t'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic ovf32(input word_t v);
    return (v > Int32Max) || (v < Int32Min);
  endfunction

  function automatic word_t sat32(input word_t v);
    word_t r;
    if (v > Int32Max) begin
      r = Int32Max;
    end else if (v < Int32Min) begin
      r = Int32Min;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ hdl/vlm_muldiv.sv @@
// ----------------------------------------------------------------------------
// vlm_muldiv
// Shared bit-serial multiplier, restoring divider and integer square root.
// ----------------------------------------------------------------------------
module vlm_muldiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vlm_pkg::unit_req_t  req_i,
  output vlm_pkg::unit_rsp_t  rsp_o
);
  import vlm_pkg::*;

  localparam logic [6:0] DivSteps = 7'd64;

  logic        busy_q;
  op_e         op_q;
  logic        neg_q;
  logic [63:0] r0_q, r1_q;
  logic [64:0] r2_q;
  logic [6:0]  cnt_q;
  logic        done_q, flag_q;
  word_t       res_q;

  logic [63:0] mag_a, mag_b;
  logic [64:0] rem_sh;
  logic [63:0] root_sum;
  logic        start;

  assign start  = req_i.valid &&
                  ((req_i.op == OP_MUL) || (req_i.op == OP_DIV) || (req_i.op == OP_SQRT));
  assign mag_a  = req_i.a[63] ? 64'(-req_i.a) : 64'(req_i.a);
  assign mag_b  = req_i.b[63] ? 64'(-req_i.b) : 64'(req_i.b);
  assign rem_sh = {r2_q[63:0], r0_q[63]};
  assign root_sum = r1_q + r2_q[63:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= OP_NONE;
      neg_q  <= 1'b0;
      r0_q   <= '0;
      r1_q   <= '0;
      r2_q   <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      flag_q <= 1'b0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        op_q   <= req_i.op;
        busy_q <= 1'b1;
        neg_q  <= req_i.a[63] ^ req_i.b[63];
        cnt_q  <= '0;
        flag_q <= 1'b0;
        case (req_i.op)
          OP_MUL: begin
            r0_q <= mag_a;
            r1_q <= mag_b;
            r2_q <= '0;
          end
          OP_DIV: begin
            r0_q <= mag_a;
            r1_q <= mag_b;
            r2_q <= '0;
            // zero divisor: answer at once with the clamp of the numerator's sign
            if (req_i.b == '0) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
              flag_q <= 1'b1;
              if (req_i.a > 0) begin
                res_q <= Int32Max;
              end else if (req_i.a < 0) begin
                res_q <= Int32Min;
              end else begin
                res_q <= '0;
              end
            end
          end
          default: begin
            r0_q <= 64'(req_i.a);
            r1_q <= '0;
            r2_q <= 65'(1) << 62;
          end
        endcase
      end else if (busy_q) begin
        case (op_q)
          OP_MUL: begin
            if (r1_q == '0) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
              res_q  <= neg_q ? -word_t'(r2_q[63:0]) : word_t'(r2_q[63:0]);
            end else begin
              if (r1_q[0]) begin
                r2_q <= r2_q + {1'b0, r0_q};
              end
              r0_q <= r0_q << 1;
              r1_q <= r1_q >> 1;
            end
          end
          OP_DIV: begin
            if (cnt_q == DivSteps) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
              res_q  <= neg_q ? -word_t'(r0_q) : word_t'(r0_q);
            end else begin
              cnt_q <= cnt_q + 7'd1;
              if (rem_sh >= {1'b0, r1_q}) begin
                r2_q <= rem_sh - {1'b0, r1_q};
                r0_q <= {r0_q[62:0], 1'b1};
              end else begin
                r2_q <= rem_sh;
                r0_q <= {r0_q[62:0], 1'b0};
              end
            end
          end
          default: begin
            if (r2_q == '0) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
              res_q  <= word_t'(r1_q);
            end else begin
              if (r0_q >= root_sum) begin
                r0_q <= r0_q - root_sum;
                r1_q <= (r1_q >> 1) + r2_q[63:0];
              end else begin
                r1_q <= r1_q >> 1;
              end
              r2_q <= r2_q >> 2;
            end
          end
        endcase
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.flag  = flag_q;
  assign rsp_o.res_a = res_q;
  assign rsp_o.res_b = '0;

endmodule

@@ hdl/vlm_cordic.sv @@
// ----------------------------------------------------------------------------
// vlm_cordic
// Iterative CORDIC: rotation for sine and cosine, vectoring for arctangent.
// ----------------------------------------------------------------------------
module vlm_cordic #(
  parameter int unsigned CORDIC_ITERATIONS = vlm_pkg::CordicIterDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vlm_pkg::unit_req_t  req_i,
  output vlm_pkg::unit_rsp_t  rsp_o
);
  import vlm_pkg::*;

  localparam logic [IterW-1:0] IterLast = IterW'(CORDIC_ITERATIONS);

  logic             busy_q, vec_q, neg_q;
  word_t            x_q, y_q, z_q;
  logic [IterW-1:0] i_q;
  logic             done_q, flag_q;
  word_t            res_a_q, res_b_q;

  word_t xs, ys, at;
  logic  pos;

  assign xs  = x_q >>> i_q;
  assign ys  = y_q >>> i_q;
  assign at  = atan_entry(i_q);
  assign pos = vec_q ? y_q[63] : !z_q[63];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      vec_q   <= 1'b0;
      neg_q   <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      i_q     <= '0;
      done_q  <= 1'b0;
      flag_q  <= 1'b0;
      res_a_q <= '0;
      res_b_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.valid && (req_i.op == OP_ROT)) begin
        busy_q <= 1'b1;
        vec_q  <= 1'b0;
        flag_q <= 1'b0;
        i_q    <= '0;
        x_q    <= Q30InvGain;
        y_q    <= '0;
        // fold the angle into plus or minus pi/2
        if (req_i.a > Q30HalfPi) begin
          z_q   <= req_i.a - Q30Pi;
          neg_q <= 1'b1;
        end else if (req_i.a < -Q30HalfPi) begin
          z_q   <= req_i.a + Q30Pi;
          neg_q <= 1'b1;
        end else begin
          z_q   <= req_i.a;
          neg_q <= 1'b0;
        end
      end else if (req_i.valid && (req_i.op == OP_VEC)) begin
        vec_q  <= 1'b1;
        neg_q  <= 1'b0;
        i_q    <= '0;
        z_q    <= '0;
        flag_q <= 1'b0;
        if (req_i.b == '0) begin
          done_q <= 1'b1;
          flag_q <= 1'b1;
          if (req_i.a > 0) begin
            res_a_q <= Q30HalfPi;
          end else if (req_i.a < 0) begin
            res_a_q <= -Q30HalfPi;
          end else begin
            res_a_q <= '0;
          end
        end else begin
          busy_q <= 1'b1;
          x_q    <= req_i.b[63] ? -req_i.b : req_i.b;
          y_q    <= req_i.b[63] ? -req_i.a : req_i.a;
        end
      end else if (busy_q) begin
        if (i_q == IterLast) begin
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
          res_a_q <= vec_q ? z_q : (neg_q ? -x_q : x_q);
          res_b_q <= neg_q ? -y_q : y_q;
        end else begin
          i_q <= i_q + 1'b1;
          if (pos) begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - at;
          end else begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + at;
          end
        end
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.flag  = flag_q;
  assign rsp_o.res_a = res_a_q;
  assign rsp_o.res_b = res_b_q;

endmodule

@@ hdl/vehicle_lateral_model_step_top.sv @@
// Timing: the time a request takes is set by the bit-serial multiplier (one
//   bit of the second operand per cycle), the 64-step divider and, for
//   dynamic requests, six CORDIC passes.
// Throughput: one request at a time; the next is taken once the result is
//   registered at the output. Reset clears state and registers to defaults.
// ----------------------------------------------------------------------------
// vehicle_lateral_model_step_top
// Bicycle model step: a small sequencer drives one shared multiply/divide/
// square-root unit and one CORDIC unit over a register file of intermediates.
// ----------------------------------------------------------------------------
module vehicle_lateral_model_step_top #(
  parameter int unsigned MIN_DYNAMIC_SPEED = vlm_pkg::MinDynSpeedDefault,
  parameter int unsigned CORDIC_ITERATIONS = vlm_pkg::CordicIterDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [19:0]        cfg_data_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [17:0] steer_angle_i,
  input  logic [22:0]        speed_i,
  input  logic [16:0]        time_step_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] yaw_rate_out_o,
  output logic signed [31:0] yaw_accel_out_o,
  output logic signed [31:0] lat_velocity_out_o,
  output logic signed [31:0] lat_accel_out_o,
  output logic signed [18:0] sideslip_out_o,
  output logic signed [31:0] front_force_out_o,
  output logic signed [31:0] rear_force_out_o,
  output logic               dynamic_mode_o,
  output logic               saturated_o
);
  import vlm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FIN} state_e;

  // One entry per micro-step of the program
  typedef enum logic [5:0] {
    SP_SINCOS, SP_KIN_NUM, SP_KIN_DEN, SP_KIN_DIV,
    SP_SPD_SQ, SP_VY_SQ, SP_DIFF, SP_SQRT,
    SP_RA, SP_RB, SP_TFR, SP_TRR,
    SP_ATF0, SP_ATF1, SP_ATR0, SP_ATR1,
    SP_FF, SP_FR, SP_AFF, SP_AFFC, SP_BFR, SP_YACC,
    SP_DTY, SP_YR, SP_FFC, SP_LAT, SP_LDIV, SP_VXYR, SP_LACC,
    SP_DTL, SP_VYO, SP_BETA, SP_FIN
  } step_e;

  state_e state_q;
  step_e  step_q;

  // configuration registers
  logic [19:0] fad_q, rad_q, fcs_q, rcs_q;
  logic [18:0] ftw_q, rtw_q;
  logic [15:0] mass_q;
  logic [17:0] inertia_q;

  // carried state
  logic signed [31:0] yaw_rate_q, lat_vel_q;

  // request and intermediates
  logic signed [17:0] del_q;
  logic [22:0]        spd_q;
  logic [16:0]        dt_q;
  word_t c16_q, s16_q, t0_q, t1_q, vx_q, vx2_q;
  word_t nf_q, nr_q, tfr_q, trr_q, sumf_q, sumr_q;
  logic signed [31:0] yr_q, yacc_q, vyo_q, lacc_q, ff_q, fr_q;
  logic signed [18:0] beta_q;
  logic               dyn_q, flag_q;

  // output register
  logic               out_valid_q;
  logic signed [31:0] o_yr_q, o_yacc_q, o_vyo_q, o_lacc_q, o_ff_q, o_fr_q;
  logic signed [18:0] o_beta_q;
  logic               o_dyn_q, o_flag_q;

  unit_req_t req;
  unit_rsp_t md_rsp, cor_rsp, rsp;
  logic      wb_en;
  step_e     step_nxt;
  word_t     vy_w, r_w;
  logic      kin;

  assign vy_w = word_t'(lat_vel_q);
  assign r_w  = word_t'(yaw_rate_q);
  assign kin  = {9'd0, speed_i} < 32'(MIN_DYNAMIC_SPEED);

  // Operation and operands of the current micro-step
  always_comb begin
    req.op = OP_NONE;
    req.a  = '0;
    req.b  = '0;
    case (step_q)
      SP_SINCOS:  begin req.op = OP_ROT; req.a = word_t'(del_q) <<< 14; end
      SP_KIN_NUM: begin req.op = OP_MUL; req.a = word_t'(spd_q); req.b = s16_q; end
      SP_KIN_DEN: begin
        req.op = OP_MUL;
        req.a  = word_t'(fad_q) + word_t'(rad_q);
        req.b  = c16_q;
      end
      SP_KIN_DIV: begin req.op = OP_DIV; req.a = t0_q; req.b = t1_q; end
      SP_SPD_SQ:  begin req.op = OP_MUL; req.a = word_t'(spd_q); req.b = word_t'(spd_q); end
      SP_VY_SQ:   begin req.op = OP_MUL; req.a = vy_w; req.b = vy_w; end
      SP_SQRT:    begin req.op = OP_SQRT; req.a = t0_q; end
      SP_RA:      begin req.op = OP_MUL; req.a = r_w; req.b = word_t'(fad_q); end
      SP_RB:      begin req.op = OP_MUL; req.a = r_w; req.b = word_t'(rad_q); end
      SP_TFR:     begin req.op = OP_MUL; req.a = word_t'(ftw_q); req.b = r_w; end
      SP_TRR:     begin req.op = OP_MUL; req.a = word_t'(rtw_q); req.b = r_w; end
      SP_ATF0:    begin req.op = OP_VEC; req.a = nf_q; req.b = vx2_q + tfr_q; end
      SP_ATF1:    begin req.op = OP_VEC; req.a = nf_q; req.b = vx2_q - tfr_q; end
      SP_ATR0:    begin req.op = OP_VEC; req.a = nr_q; req.b = vx2_q + trr_q; end
      SP_ATR1:    begin req.op = OP_VEC; req.a = nr_q; req.b = vx2_q - trr_q; end
      SP_FF:      begin req.op = OP_MUL; req.a = -word_t'(fcs_q); req.b = sumf_q; end
      SP_FR:      begin req.op = OP_MUL; req.a = -word_t'(rcs_q); req.b = sumr_q; end
      SP_AFF:     begin req.op = OP_MUL; req.a = word_t'(fad_q); req.b = word_t'(ff_q); end
      SP_AFFC:    begin req.op = OP_MUL; req.a = t0_q; req.b = c16_q; end
      SP_BFR:     begin req.op = OP_MUL; req.a = word_t'(rad_q); req.b = word_t'(fr_q); end
      SP_YACC:    begin req.op = OP_DIV; req.a = t0_q; req.b = word_t'(inertia_q); end
      SP_DTY:     begin req.op = OP_MUL; req.a = word_t'(dt_q); req.b = word_t'(yacc_q); end
      SP_FFC:     begin req.op = OP_MUL; req.a = word_t'(ff_q); req.b = c16_q; end
      SP_LDIV:    begin req.op = OP_DIV; req.a = t0_q; req.b = word_t'(mass_q); end
      SP_VXYR:    begin req.op = OP_MUL; req.a = vx_q; req.b = word_t'(yr_q); end
      SP_DTL:     begin req.op = OP_MUL; req.a = word_t'(dt_q); req.b = word_t'(lacc_q); end
      SP_BETA:    begin req.op = OP_VEC; req.a = word_t'(vyo_q); req.b = vx_q; end
      default:    req.op = OP_NONE;
    endcase
    req.valid = (state_q == ST_ISSUE) && (req.op != OP_NONE);
  end

  // Sequence: kinematic branch stops after its division
  always_comb begin
    case (step_q)
      SP_SINCOS:  step_nxt = dyn_q ? SP_SPD_SQ : SP_KIN_NUM;
      SP_KIN_DIV: step_nxt = SP_FIN;
      SP_FIN:     step_nxt = SP_FIN;
      default:    step_nxt = step_e'(step_q + 6'd1);
    endcase
  end

  vlm_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (md_rsp)
  );

  vlm_cordic #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (cor_rsp)
  );

  assign rsp   = cor_rsp.done ? cor_rsp : md_rsp;
  assign wb_en = ((state_q == ST_ISSUE) && (req.op == OP_NONE)) ||
                 ((state_q == ST_WAIT) && rsp.done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= SP_SINCOS;
      fad_q       <= FrontAxleRst;
      rad_q       <= RearAxleRst;
      ftw_q       <= FrontTrackRst;
      rtw_q       <= RearTrackRst;
      fcs_q       <= FrontStiffRst;
      rcs_q       <= RearStiffRst;
      mass_q      <= MassRst;
      inertia_q   <= InertiaRst;
      yaw_rate_q  <= '0;
      lat_vel_q   <= '0;
      del_q       <= '0;
      spd_q       <= '0;
      dt_q        <= '0;
      c16_q       <= '0;
      s16_q       <= '0;
      t0_q        <= '0;
      t1_q        <= '0;
      vx_q        <= '0;
      vx2_q       <= '0;
      nf_q        <= '0;
      nr_q        <= '0;
      tfr_q       <= '0;
      trr_q       <= '0;
      sumf_q      <= '0;
      sumr_q      <= '0;
      yr_q        <= '0;
      yacc_q      <= '0;
      vyo_q       <= '0;
      lacc_q      <= '0;
      ff_q        <= '0;
      fr_q        <= '0;
      beta_q      <= '0;
      dyn_q       <= 1'b0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      o_yr_q      <= '0;
      o_yacc_q    <= '0;
      o_vyo_q     <= '0;
      o_lacc_q    <= '0;
      o_ff_q      <= '0;
      o_fr_q      <= '0;
      o_beta_q    <= '0;
      o_dyn_q     <= 1'b0;
      o_flag_q    <= 1'b0;
    end else begin
      // user keeps configuration writes to idle, unenforced; taken at once
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FRONT_AXLE:  fad_q     <= cfg_data_i;
          CFG_REAR_AXLE:   rad_q     <= cfg_data_i;
          CFG_FRONT_TRACK: ftw_q     <= cfg_data_i[18:0];
          CFG_REAR_TRACK:  rtw_q     <= cfg_data_i[18:0];
          CFG_FRONT_STIFF: fcs_q     <= cfg_data_i;
          CFG_REAR_STIFF:  rcs_q     <= cfg_data_i;
          CFG_MASS:        mass_q    <= cfg_data_i[15:0];
          CFG_INERTIA:     inertia_q <= cfg_data_i[17:0];
          default: ;
        endcase
      end

      // drop the result once taken
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            del_q   <= steer_angle_i;
            spd_q   <= speed_i;
            dt_q    <= time_step_i;
            dyn_q   <= !kin;
            flag_q  <= 1'b0;
            yacc_q  <= '0;
            vyo_q   <= '0;
            lacc_q  <= '0;
            ff_q    <= '0;
            fr_q    <= '0;
            beta_q  <= '0;
            step_q  <= SP_SINCOS;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (req.op != OP_NONE) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: ;
        ST_FIN: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            o_yr_q      <= yr_q;
            o_yacc_q    <= yacc_q;
            o_vyo_q     <= vyo_q;
            o_lacc_q    <= lacc_q;
            o_ff_q      <= ff_q;
            o_fr_q      <= fr_q;
            o_beta_q    <= beta_q;
            o_dyn_q     <= dyn_q;
            o_flag_q    <= flag_q;
            yaw_rate_q  <= yr_q;
            lat_vel_q   <= vyo_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // write back the current micro-step and advance
      if (wb_en) begin
        step_q  <= step_nxt;
        state_q <= (step_nxt == SP_FIN) ? ST_FIN : ST_ISSUE;
        if (rsp.flag && (req.op != OP_NONE)) begin
          flag_q <= 1'b1;
        end
        case (step_q)
          SP_SINCOS: begin
            c16_q <= rnd_shift(rsp.res_a, 14);
            s16_q <= rnd_shift(rsp.res_b, 14);
          end
          SP_KIN_NUM: t0_q <= rsp.res_a <<< 16;
          SP_KIN_DEN: t1_q <= rsp.res_a;
          SP_KIN_DIV: begin
            yr_q <= 32'(sat32(rsp.res_a));
            if (ovf32(rsp.res_a)) flag_q <= 1'b1;
          end
          SP_SPD_SQ: t0_q <= rsp.res_a;
          SP_VY_SQ:  t1_q <= rsp.res_a;
          SP_DIFF: begin
            // negative square: longitudinal speed clamps at zero
            if (t0_q < t1_q) begin
              t0_q   <= '0;
              flag_q <= 1'b1;
            end else begin
              t0_q <= t0_q - t1_q;
            end
          end
          SP_SQRT: begin
            vx_q  <= rsp.res_a;
            vx2_q <= rsp.res_a <<< 17;
          end
          SP_RA:   nf_q  <= ((vy_w <<< 16) + rsp.res_a) <<< 1;
          SP_RB:   nr_q  <= ((vy_w <<< 16) - rsp.res_a) <<< 1;
          SP_TFR:  tfr_q <= rsp.res_a;
          SP_TRR:  trr_q <= rsp.res_a;
          SP_ATF0: sumf_q <= rsp.res_a - (word_t'(del_q) <<< 15);
          SP_ATF1: sumf_q <= sumf_q + rsp.res_a;
          SP_ATR0: sumr_q <= rsp.res_a;
          SP_ATR1: sumr_q <= sumr_q + rsp.res_a;
          SP_FF: begin
            ff_q <= 32'(sat32(rnd_shift(rsp.res_a, 30)));
            if (ovf32(rnd_shift(rsp.res_a, 30))) flag_q <= 1'b1;
          end
          SP_FR: begin
            fr_q <= 32'(sat32(rnd_shift(rsp.res_a, 30)));
            if (ovf32(rnd_shift(rsp.res_a, 30))) flag_q <= 1'b1;
          end
          SP_AFF:  t0_q <= rsp.res_a;
          SP_AFFC: t0_q <= rnd_shift(rsp.res_a, 16);
          SP_BFR:  t0_q <= t0_q - rsp.res_a;
          SP_YACC: begin
            yacc_q <= 32'(sat32(rsp.res_a));
            if (ovf32(rsp.res_a)) flag_q <= 1'b1;
          end
          SP_DTY: t1_q <= rnd_shift(rsp.res_a, 16);
          SP_YR: begin
            yr_q <= 32'(sat32(r_w + t1_q));
            if (ovf32(r_w + t1_q)) flag_q <= 1'b1;
          end
          SP_FFC:  t0_q <= rsp.res_a;
          SP_LAT:  t0_q <= t0_q + (word_t'(fr_q) <<< 16);
          SP_LDIV: t1_q <= rsp.res_a;
          SP_VXYR: t0_q <= rnd_shift(rsp.res_a, 16);
          SP_LACC: begin
            lacc_q <= 32'(sat32(t1_q - t0_q));
            if (ovf32(t1_q - t0_q)) flag_q <= 1'b1;
          end
          SP_DTL: t1_q <= rnd_shift(rsp.res_a, 16);
          SP_VYO: begin
            vyo_q <= 32'(sat32(vy_w + t1_q));
            if (ovf32(vy_w + t1_q)) flag_q <= 1'b1;
          end
          SP_BETA: beta_q <= 19'(rnd_shift(rsp.res_a, 14));
          default: ;
        endcase
      end
    end
  end

  assign cfg_ready_o        = 1'b1;
  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign yaw_rate_out_o     = o_yr_q;
  assign yaw_accel_out_o    = o_yacc_q;
  assign lat_velocity_out_o = o_vyo_q;
  assign lat_accel_out_o    = o_lacc_q;
  assign sideslip_out_o     = o_beta_q;
  assign front_force_out_o  = o_ff_q;
  assign rear_force_out_o   = o_fr_q;
  assign dynamic_mode_o     = o_dyn_q;
  assign saturated_o        = o_flag_q;

endmodule

@@ hdl/vlm_checker.sv @@
// ----------------------------------------------------------------------------
// vlm_checker
// Port-level checks on the lateral model step, bound to the top level.
// ----------------------------------------------------------------------------
`include "vehicle_lateral_model_step_top_macros.svh"

module vlm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] yaw_accel_out_o,
  input logic signed [31:0] lat_velocity_out_o,
  input logic signed [31:0] front_force_out_o,
  input logic signed [18:0] sideslip_out_o,
  input logic               dynamic_mode_o
);

  `VLM_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  `VLM_ASSERT_NXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o)

  `VLM_ASSERT_IMP(a_kin_zero, out_valid_o && !dynamic_mode_o, (yaw_accel_out_o == 0) && (lat_velocity_out_o == 0) && (front_force_out_o == 0))

  `VLM_ASSERT_IMP(a_slip_range, out_valid_o, (sideslip_out_o >= -19'sd205888) && (sideslip_out_o <= 19'sd205888))

endmodule

bind vehicle_lateral_model_step_top vlm_checker u_vlm_checker (.*);

@@ bench/tb_vehicle_lateral_model_step_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lateral vehicle model step testbench
// Drives steering/speed/time-step requests through several register settings,
// predicts each response with an in-bench bicycle model and checks every field.
// ----------------------------------------------------------------------------
module tb_vehicle_lateral_model_step_top;
  import vlm_pkg::*;

  localparam int unsigned MinSpeed   = 327680;
  localparam int unsigned CordicIter = 20;
  localparam longint     HalfPiQ30  = 64'sd1686629713;
  localparam longint     PiQ30      = 64'sd3373259426;
  localparam longint     InvGainQ30 = 64'sd652032874;
  localparam longint     S32Max     = 64'sd2147483647;
  localparam longint     S32Min     = -64'sd2147483648;
  // settle time after the last response, above the worst dynamic latency
  localparam int unsigned DrainCycles = 1600;

  // arctangent of 2^-i in Q30
  localparam longint AtanQ30 [20] = '{
    843314857, 497837830, 263043837, 133525159, 67021687, 33543515,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048
  };

  typedef struct {
    logic signed [17:0] steer;
    logic [22:0]        speed;
    logic [16:0]        dt;
  } step_req_t;

  typedef struct {
    logic signed [31:0] yaw_rate;
    logic signed [31:0] yaw_accel;
    logic signed [31:0] lat_vel;
    logic signed [31:0] lat_accel;
    logic signed [18:0] sideslip;
    logic signed [31:0] front_force;
    logic signed [31:0] rear_force;
    logic               dyn;
    logic               sat;
  } step_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [19:0]        cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic signed [17:0] steer_angle_i = '0;
  logic [22:0]        speed_i       = '0;
  logic [16:0]        time_step_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic signed [31:0] yaw_rate_out_o, yaw_accel_out_o, lat_velocity_out_o;
  logic signed [31:0] lat_accel_out_o, front_force_out_o, rear_force_out_o;
  logic signed [18:0] sideslip_out_o;
  logic               dynamic_mode_o, saturated_o;

  vehicle_lateral_model_step_top uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: own copy of the registers and of the integrated state
  // --------------------------------------------------------------------------
  logic [19:0]        front_dist, rear_dist, front_stiff, rear_stiff;
  logic [18:0]        front_trk, rear_trk;
  logic [15:0]        mass_kg;
  logic [17:0]        inertia;
  logic signed [31:0] yaw_rate_st, lat_vel_st;
  bit                 clamp_hit;

  step_req_t pending_reqs[$];
  step_rsp_t expected_rsps[$];
  int unsigned mismatches = 0;

  function automatic longint round_shift(longint v, int unsigned n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function longint clamp32(longint v);
    if (v > S32Max) begin
      clamp_hit = 1'b1;
      return S32Max;
    end
    if (v < S32Min) begin
      clamp_hit = 1'b1;
      return S32Min;
    end
    return v;
  endfunction

  function longint quot(longint num, longint den);
    if (den == 0) begin
      clamp_hit = 1'b1;
      return num > 0 ? S32Max : (num < 0 ? S32Min : 0);
    end
    return num / den;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // rotate the unit vector to the steering angle; cos and sin out in Q16.16
  function automatic void steer_sincos(longint ang, output longint c16,
                                       output longint s16);
    longint z, x, y, dx, dy;
    bit flip;
    z = ang * 16384;
    x = InvGainQ30;
    y = 0;
    flip = 1'b0;
    if (z > HalfPiQ30) begin
      z = z - PiQ30;
      flip = 1'b1;
    end else if (z < -HalfPiQ30) begin
      z = z + PiQ30;
      flip = 1'b1;
    end
    for (int i = 0; i < CordicIter; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - AtanQ30[i];
      end else begin
        x = x + dx; y = y - dy; z = z + AtanQ30[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c16 = round_shift(x, 14);
    s16 = round_shift(y, 14);
  endfunction

  // angle of p/q in Q30 by vectoring
  function longint slip_angle(longint p, longint q);
    longint x, y, z, xs;
    z = 0;
    if (q == 0) begin
      clamp_hit = 1'b1;
      return p > 0 ? HalfPiQ30 : (p < 0 ? -HalfPiQ30 : 0);
    end
    if (q < 0) begin
      p = -p;
      q = -q;
    end
    x = q;
    y = p;
    for (int i = 0; i < CordicIter; i++) begin
      xs = x >>> i;
      if (y >= 0) begin
        x = x + (y >>> i); y = y - xs; z = z + AtanQ30[i];
      end else begin
        x = x - (y >>> i); y = y + xs; z = z - AtanQ30[i];
      end
    end
    return z;
  endfunction

  function step_rsp_t bicycle_step(step_req_t rq);
    step_rsp_t r;
    longint del, spd, dt, a, b, c16, s16;
    longint yr, yacc, vyo, lacc, beta, ff, fr;
    longint vy, wz, diff, vx, vx2, vys, nf, nr, tfr, trr, sumf, sumr, mom, lat;
    del = rq.steer;
    spd = rq.speed;
    dt  = rq.dt;
    a   = front_dist;
    b   = rear_dist;
    yr = 0; yacc = 0; vyo = 0; lacc = 0; beta = 0; ff = 0; fr = 0;
    clamp_hit = 1'b0;
    steer_sincos(del, c16, s16);
    r.dyn = spd >= MinSpeed;
    if (!r.dyn) begin
      yr = clamp32(quot(spd * s16 * 65536, (a + b) * c16));
    end else begin
      vy = lat_vel_st;
      wz = yaw_rate_st;
      diff = spd * spd - vy * vy;
      if (diff < 0) begin
        diff = 0;
        clamp_hit = 1'b1;
      end
      vx   = longint'(int_sqrt(diff));
      vys  = vy * 65536;
      vx2  = 2 * vx * 65536;
      nf   = 2 * (vys + wz * a);
      nr   = 2 * (vys - wz * b);
      tfr  = longint'(front_trk) * wz;
      trr  = longint'(rear_trk) * wz;
      sumf = slip_angle(nf, vx2 + tfr) + slip_angle(nf, vx2 - tfr) - 2 * del * 16384;
      sumr = slip_angle(nr, vx2 + trr) + slip_angle(nr, vx2 - trr);
      ff   = clamp32(round_shift(-longint'(front_stiff) * sumf, 30));
      fr   = clamp32(round_shift(-longint'(rear_stiff) * sumr, 30));
      mom  = round_shift(a * ff * c16, 16) - b * fr;
      yacc = clamp32(quot(mom, longint'(inertia)));
      yr   = clamp32(wz + round_shift(dt * yacc, 16));
      lat  = ff * c16 + fr * 65536;
      lacc = clamp32(quot(lat, longint'(mass_kg)) - round_shift(vx * yr, 16));
      vyo  = clamp32(vy + round_shift(dt * lacc, 16));
      beta = round_shift(slip_angle(vyo, vx), 14);
    end
    yaw_rate_st = yr[31:0];
    lat_vel_st  = vyo[31:0];
    r.yaw_rate    = yr[31:0];
    r.yaw_accel   = yacc[31:0];
    r.lat_vel     = vyo[31:0];
    r.lat_accel   = lacc[31:0];
    r.sideslip    = beta[18:0];
    r.front_force = ff[31:0];
    r.rear_force  = fr[31:0];
    r.sat         = clamp_hit;
    return r;
  endfunction

  // track register writes and accepted requests at the handshake
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_dist  = FrontAxleRst;
      rear_dist   = RearAxleRst;
      front_trk   = FrontTrackRst;
      rear_trk    = RearTrackRst;
      front_stiff = FrontStiffRst;
      rear_stiff  = RearStiffRst;
      mass_kg     = MassRst;
      inertia     = InertiaRst;
      yaw_rate_st = '0;
      lat_vel_st  = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FRONT_AXLE:  front_dist  = cfg_data_i;
          CFG_REAR_AXLE:   rear_dist   = cfg_data_i;
          CFG_FRONT_TRACK: front_trk   = cfg_data_i[18:0];
          CFG_REAR_TRACK:  rear_trk    = cfg_data_i[18:0];
          CFG_FRONT_STIFF: front_stiff = cfg_data_i;
          CFG_REAR_STIFF:  rear_stiff  = cfg_data_i;
          CFG_MASS:        mass_kg     = cfg_data_i[15:0];
          CFG_INERTIA:     inertia     = cfg_data_i[17:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        expected_rsps.push_back(bicycle_step('{steer_angle_i, speed_i, time_step_i}));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length, random gaps in between
  // --------------------------------------------------------------------------
  int unsigned burst_left, gap_left;
  step_req_t   nxt;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        steer_angle_i <= nxt.steer;
        speed_i       <= nxt.speed;
        time_step_i   <= nxt.dt;
        in_valid_i    <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          // leave some bursts back to back
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response side: ready follows a rotating pattern, reshuffled now and then
  // --------------------------------------------------------------------------
  logic [15:0] ready_pat;
  int unsigned pat_age;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_pat = 16'hffff;
      pat_age   = 0;
    end else begin
      out_ready_i <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[15:1]};
      if (++pat_age == 700) begin
        pat_age = 0;
        // a quarter of the time, never stall at all
        ready_pat = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom) | 16'h0001;
      end
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  step_rsp_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsps.size() == 0) begin
        $error("response with nothing outstanding");
        mismatches++;
      end else begin
        want = expected_rsps.pop_front();
        check_field("yaw_rate_out", want.yaw_rate, yaw_rate_out_o);
        check_field("yaw_accel_out", want.yaw_accel, yaw_accel_out_o);
        check_field("lat_velocity_out", want.lat_vel, lat_velocity_out_o);
        check_field("lat_accel_out", want.lat_accel, lat_accel_out_o);
        check_field("sideslip_out", want.sideslip, sideslip_out_o);
        check_field("front_force_out", want.front_force, front_force_out_o);
        check_field("rear_force_out", want.rear_force, rear_force_out_o);
        check_field("dynamic_mode", want.dyn, dynamic_mode_o);
        check_field("saturated", want.sat, saturated_o);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: registers only while idle, then a batch of requests per setting
  // --------------------------------------------------------------------------
  task automatic add_req(int steer, int unsigned spd, int unsigned dt);
    pending_reqs.push_back('{18'(steer), 23'(spd), 17'(dt)});
  endtask

  // hold valid high across back-to-back writes; the caller drops it
  task automatic write_reg(cfg_idx_e idx, logic [19:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic write_all(logic [19:0] a, logic [19:0] b, logic [18:0] tf,
                           logic [18:0] tr, logic [19:0] cf, logic [19:0] cr,
                           logic [15:0] m, logic [17:0] iz);
    write_reg(CFG_FRONT_AXLE, a);
    write_reg(CFG_REAR_AXLE, b);
    write_reg(CFG_FRONT_TRACK, tf);
    write_reg(CFG_REAR_TRACK, tr);
    write_reg(CFG_FRONT_STIFF, cf);
    write_reg(CFG_REAR_STIFF, cr);
    write_reg(CFG_MASS, m);
    write_reg(CFG_INERTIA, iz);
    cfg_valid_i <= 1'b0;
  endtask

  // wait for the pipe to empty, then let the block settle
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // mostly plausible driving so the integrated state evolves, plus noise
  task automatic add_random(int unsigned count);
    int unsigned kind;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        add_req($urandom_range(0, 40000) - 20000, $urandom_range(MinSpeed, 2621440),
                $urandom_range(0, 3277));
      end else if (kind < 80) begin
        add_req($urandom_range(0, 205888) - 102944, $urandom_range(0, MinSpeed - 1),
                $urandom_range(0, 65536));
      end else begin
        add_req($urandom_range(0, 205888) - 102944, $urandom_range(0, 6553600),
                $urandom_range(0, 65536));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes and the mode boundary on reset registers
    add_req(0, 0, 0);
    add_req(102944, 100000, 65536);
    add_req(-102944, 100000, 65536);
    add_req(102944, MinSpeed - 1, 1000);
    add_req(-102944, MinSpeed - 1, 1000);
    add_req(0, MinSpeed, 0);
    add_req(5000, MinSpeed, 655);
    add_req(5000, 1310720, 655);
    add_req(-5000, 1310720, 65536);
    add_req(102944, 6553600, 65536);
    add_req(-102944, 6553600, 65536);
    add_req(0, 6553600, 1);
    // lateral velocity now large: drop speed below it
    add_req(20000, MinSpeed, 65536);
    add_req(-1, MinSpeed + 1, 65536);
    add_req(1, 0, 0);
    add_req(0, MinSpeed, 65535);
    add_random(180);
    drain();

    // largest geometry and stiffness
    write_all(20'd655360, 20'd655360, 19'd327680, 19'd327680, 20'd1000000,
              20'd1000000, 16'd50000, 18'd200000);
    add_random(180);
    drain();

    // zero geometry and stiffness, unit mass and inertia
    write_all(20'd0, 20'd0, 19'd0, 19'd0, 20'd0, 20'd0, 16'd1, 18'd1);
    add_req(102944, 100000, 100);
    add_req(0, 0, 0);
    add_random(160);
    drain();

    // small mass and inertia with stiff tyres: overflow territory
    write_all(20'd65536, 20'd65536, 19'd327680, 19'd0, 20'd1000000, 20'd1000000,
              16'd1, 18'd1);
    add_random(160);
    drain();

    repeat (4) begin
      write_all(20'($urandom_range(0, 655360)), 20'($urandom_range(0, 655360)),
                19'($urandom_range(0, 327680)), 19'($urandom_range(0, 327680)),
                20'($urandom_range(0, 1000000)), 20'($urandom_range(0, 1000000)),
                16'($urandom_range(1, 50000)), 18'($urandom_range(1, 200000)));
      add_random(140);
      drain();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
